### src/tti_pkg.sv
// Shared widths, reset values and character codes for the text-to-integer parser.
// No dependencies; compiled before the interfaces and the top level.
package tti_pkg;

	localparam int CH_W          = 8;
	localparam int VALUE_W       = 32;
	localparam int ALPHA_BYTES   = 32;
	localparam int LEN_W         = 6;
	localparam int CFG_W         = 64;
	localparam int ADDR_W        = 6;
	localparam int MAX_RADIX_DEF = 32;

	localparam logic [LEN_W-1:0] RESET_RADIX_LEN = 6'd10;
	localparam logic [CFG_W-1:0] RESET_ALPHA_0   = 64'h3736_3534_3332_3130;
	localparam logic [CFG_W-1:0] RESET_ALPHA_1   = 64'h0000_0000_0000_3938;
	localparam logic [CFG_W-1:0] RESET_ALPHA_2   = 64'h0;
	localparam logic [CFG_W-1:0] RESET_ALPHA_3   = 64'h0;

	localparam logic [CH_W-1:0] CH_TAB   = 8'd9;
	localparam logic [CH_W-1:0] CH_CR    = 8'd13;
	localparam logic [CH_W-1:0] CH_SPACE = 8'd32;
	localparam logic [CH_W-1:0] CH_PLUS  = 8'd43;
	localparam logic [CH_W-1:0] CH_MINUS = 8'd45;
	localparam logic [CH_W-1:0] CH_NUL   = 8'd0;

	typedef logic [CH_W-1:0]    ch_t;
	typedef logic [VALUE_W-1:0] value_t;

	function automatic logic is_space(input ch_t c);
		return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
	endfunction

endpackage

### src/tti_if.sv
// Valid/ready channel interfaces for characters in and parsed results out.
// Depends on tti_pkg for the payload types.
interface tti_char_if;
	logic          valid;
	logic          ready;
	tti_pkg::ch_t  ch;
	logic          last;

	modport source (output valid, ch, last, input ready);
	modport sink   (input valid, ch, last, output ready);
endinterface

interface tti_result_if;
	logic             valid;
	logic             ready;
	tti_pkg::value_t  value;
	logic             alphabet_invalid;
	logic             overflowed;

	modport source (output valid, value, alphabet_invalid, overflowed, input ready);
	modport sink   (input valid, value, alphabet_invalid, overflowed, output ready);
endinterface

### src/text_to_integer_custom_radix.sv
// Streaming integer parser with a configurable digit alphabet, APB register port.
// Depends on tti_pkg and the channel interfaces in tti_if.sv.
//
//   channel | dir | payload                                  | transfer
//   chars   | in  | ch[7:0], last                            | valid & ready
//   result  | out | value[31:0], alphabet_invalid, overflowed | valid & ready
//   apb     | in  | paddr[5:3] selects register, 64-bit data | psel & penable & pwrite
//
// One character per cycle while the result register is not stalled. A character is
// held in the input register, then the alphabet compare and the multiply-add on the
// accumulator update the parse state; a last character loads the result register, so
// a result passes the input register and then the result register before it is valid.
// A stalled result register holds only a last character in the input stage; other
// characters keep flowing.
// Alphabet length and validity are registered again from the configuration registers.
// Reset clears the parse state and restores the default decimal alphabet.
module text_to_integer_custom_radix #(
	parameter int MAX_RADIX = tti_pkg::MAX_RADIX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	tti_char_if.sink                        chars,
	tti_result_if.source                    result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tti_pkg::ADDR_W-1:0]      paddr,
	input  logic [tti_pkg::CFG_W-1:0]       pwdata,
	output logic [tti_pkg::CFG_W-1:0]       prdata,
	output logic                            pready
);

	localparam int NB    = tti_pkg::ALPHA_BYTES;
	localparam int LW    = tti_pkg::LEN_W;
	localparam int VW    = tti_pkg::VALUE_W;
	localparam int LIM_I = (MAX_RADIX < NB) ? MAX_RADIX : NB;
	localparam logic [LW-1:0] LIM = LW'(LIM_I);
	localparam logic [LW-1:0] LEN_RST =
		(tti_pkg::RESET_RADIX_LEN > LIM) ? LIM : tti_pkg::RESET_RADIX_LEN;
	localparam int DW    = $clog2(NB);
	localparam int PW    = VW + LW;

	localparam logic [2:0] REG_RADIX = 3'd0;
	localparam logic [2:0] REG_ALPHA0 = 3'd1;
	localparam logic [2:0] REG_ALPHA1 = 3'd2;
	localparam logic [2:0] REG_ALPHA2 = 3'd3;
	localparam logic [2:0] REG_ALPHA3 = 3'd4;

	localparam logic [1:0] PH_WS    = 2'd0;
	localparam logic [1:0] PH_SIGN  = 2'd1;
	localparam logic [1:0] PH_DIGIT = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	// configuration registers
	logic [LW-1:0]                 radix_q;
	logic [3:0][tti_pkg::CFG_W-1:0] alpha_q;
	logic [NB*8-1:0]               alpha_flat;
	logic [2:0]                    reg_idx;
	logic                          cfg_wr;

	assign pready     = 1'b1;
	assign reg_idx    = paddr[5:3];
	assign cfg_wr     = psel && penable && pwrite;
	assign alpha_flat = {alpha_q[3], alpha_q[2], alpha_q[1], alpha_q[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q    <= tti_pkg::RESET_RADIX_LEN;
			alpha_q[0] <= tti_pkg::RESET_ALPHA_0;
			alpha_q[1] <= tti_pkg::RESET_ALPHA_1;
			alpha_q[2] <= tti_pkg::RESET_ALPHA_2;
			alpha_q[3] <= tti_pkg::RESET_ALPHA_3;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_RADIX:  radix_q    <= pwdata[LW-1:0];
				REG_ALPHA0: alpha_q[0] <= pwdata;
				REG_ALPHA1: alpha_q[1] <= pwdata;
				REG_ALPHA2: alpha_q[2] <= pwdata;
				REG_ALPHA3: alpha_q[3] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_RADIX:  prdata = {{(tti_pkg::CFG_W-LW){1'b0}}, radix_q};
			REG_ALPHA0: prdata = alpha_q[0];
			REG_ALPHA1: prdata = alpha_q[1];
			REG_ALPHA2: prdata = alpha_q[2];
			REG_ALPHA3: prdata = alpha_q[3];
			default:    prdata = '0;
		endcase
	end

	// effective alphabet length and validity, registered
	logic [LW-1:0] clamp_len;
	logic [LW-1:0] eff_len;
	logic          eff_bad;
	logic          zero_found;
	logic [LW-1:0] len_q;
	logic          invalid_q;

	always_comb begin
		clamp_len  = (radix_q > LIM) ? LIM : radix_q;
		eff_len    = clamp_len;
		zero_found = 1'b0;
		for (int k = 0; k < NB; k++) begin
			if (!zero_found && (LW'(k) < clamp_len)
					&& (alpha_flat[k*8 +: 8] == tti_pkg::CH_NUL)) begin
				eff_len    = LW'(k);
				zero_found = 1'b1;
			end
		end
		eff_bad = (eff_len < LW'(2));
		for (int i = 0; i < NB; i++) begin
			if (LW'(i) < eff_len) begin
				if (tti_pkg::is_space(alpha_flat[i*8 +: 8])
						|| (alpha_flat[i*8 +: 8] == tti_pkg::CH_PLUS)
						|| (alpha_flat[i*8 +: 8] == tti_pkg::CH_MINUS))
					eff_bad = 1'b1;
				for (int j = i + 1; j < NB; j++) begin
					if ((LW'(j) < eff_len) && (alpha_flat[j*8 +: 8] == alpha_flat[i*8 +: 8]))
						eff_bad = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= LEN_RST;
			invalid_q <= 1'b0;
		end else begin
			len_q     <= eff_len;
			invalid_q <= eff_bad;
		end
	end

	// input register
	logic          valid_s1;
	tti_pkg::ch_t  ch_s1;
	logic          last_s1;
	logic          out_valid_q;
	logic          advance;

	assign advance     = valid_s1 && (!last_s1 || !out_valid_q || result.ready);
	assign chars.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			ch_s1   <= chars.ch;
			last_s1 <= chars.last;
		end
	end

	// digit match: lowest alphabet position that equals the character
	logic          hit;
	logic [DW-1:0] digit;

	always_comb begin
		hit   = 1'b0;
		digit = '0;
		for (int k = 0; k < NB; k++) begin
			if (!hit && (LW'(k) < len_q) && (alpha_flat[k*8 +: 8] == ch_s1)) begin
				hit   = 1'b1;
				digit = DW'(k);
			end
		end
	end

	// parse state
	logic [1:0]     phase_q;
	logic           parity_q;
	tti_pkg::value_t acc_q;
	logic           wrap_q;

	logic [1:0]     phase_n;
	logic           parity_n;
	tti_pkg::value_t acc_n;
	logic           wrap_n;
	logic [PW-1:0]  prod;
	logic [PW-1:0]  wide;

	assign prod = PW'(acc_q) * PW'(len_q);
	assign wide = prod + PW'(digit);

	always_comb begin
		phase_n  = phase_q;
		parity_n = parity_q;
		acc_n    = acc_q;
		wrap_n   = wrap_q;
		if ((phase_n == PH_WS) && !tti_pkg::is_space(ch_s1))
			phase_n = PH_SIGN;
		if (phase_n == PH_SIGN) begin
			if (ch_s1 == tti_pkg::CH_MINUS)
				parity_n = ~parity_n;
			else if (ch_s1 != tti_pkg::CH_PLUS)
				phase_n = PH_DIGIT;
		end
		if (phase_n == PH_DIGIT) begin
			if (!hit) begin
				phase_n = PH_DONE;
			end else begin
				acc_n = wide[VW-1:0];
				if (wide[PW-1:VW] != '0)
					wrap_n = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WS;
			parity_q <= 1'b0;
			acc_q    <= '0;
			wrap_q   <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				phase_q  <= PH_WS;
				parity_q <= 1'b0;
				acc_q    <= '0;
				wrap_q   <= 1'b0;
			end else begin
				phase_q  <= phase_n;
				parity_q <= parity_n;
				acc_q    <= acc_n;
				wrap_q   <= wrap_n;
			end
		end
	end

	// result register
	tti_pkg::value_t value_q;
	logic            bad_q;
	logic            ovf_q;
	logic            load_out;

	assign load_out = advance && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			bad_q   <= invalid_q;
			ovf_q   <= invalid_q ? 1'b0 : wrap_n;
			value_q <= invalid_q ? '0 : (parity_n ? (VW'(0) - acc_n) : acc_n);
		end
	end

	assign result.valid            = out_valid_q;
	assign result.value            = value_q;
	assign result.alphabet_invalid = bad_q;
	assign result.overflowed       = ovf_q;

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && bad_q) |-> (value_q == '0) && !ovf_q)
		else $error("invalid alphabet result carries a nonzero value or overflow");

	a_last_loads: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q)
		else $error("last character did not produce a result");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> chars.ready)
		else $error("input stalled with an empty input register");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LIM)
		else $error("alphabet length exceeds the stored bytes");

	a_state_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (phase_q == PH_WS) && !parity_q && (acc_q == '0) && !wrap_q)
		else $error("parse state not cleared after a last character");

endmodule
